@@ design/rep_pkg.sv @@
// Shared types and codes for the red-eye pixel correction core.
package rep_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_METHOD_SELECT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_MIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OTHER_MAX     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HUE_LOW       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HUE_HIGH      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SAT_MIN       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_VAL_MIN       = 3'd6;

    localparam logic [1:0] METHOD_RGB   = 2'd0;
    localparam logic [1:0] METHOD_RATIO = 2'd1;
    localparam logic [1:0] METHOD_HSV   = 2'd2;

    typedef struct packed {
        logic [1:0] method_select;
        logic [7:0] red_min;
        logic [7:0] other_max;
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_min;
        logic [7:0] val_min;
    } cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       eye;
    } pix_t;

endpackage

@@ design/red_eye_pixel_correct_core.sv @@
// Pipeline: five register stages, s1 to s4 in rep_classify and then the output register.
// Throughput: one word per clock; the whole pipeline holds while out_stall holds a word.
// in_stall is high only while an output word is waiting and out_stall is high.
// Reset clears all valid bits and loads the registers with their default thresholds.
// Top level of the red-eye pixel correction core.
module red_eye_pixel_correct_core
    import rep_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_blue,
    input  logic [7:0]             in_green,
    input  logic [7:0]             in_red,
    input  logic                   in_eye,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_blue,
    output logic [7:0]             out_green,
    output logic [7:0]             out_red,
    output logic                   was_red,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    pix_t       in_pix;
    logic       advance;
    logic       cls_valid;
    pix_t       cls_pix;
    logic       cls_is_red;
    logic       fix;
    logic [8:0] grey_sum;
    logic [7:0] grey;

    logic       out_valid_reg;
    pix_t       out_pix_reg;
    logic       was_red_reg;
    pix_t       out_pix_next;

    assign advance = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    assign in_pix.blue  = in_blue;
    assign in_pix.green = in_green;
    assign in_pix.red   = in_red;
    assign in_pix.eye   = in_eye;

    rep_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rep_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_load    (in_valid),
        .in_pix     (in_pix),
        .cfg        (cfg),
        .out_valid  (cls_valid),
        .out_pix    (cls_pix),
        .out_is_red (cls_is_red)
    );

    always_comb
    begin
        fix      = cls_is_red && cls_pix.eye;
        grey_sum = {1'b0, cls_pix.green} + {1'b0, cls_pix.blue};
        grey     = grey_sum[8:1];
        out_pix_next = cls_pix;
        if (fix)
        begin
            out_pix_next.blue  = grey;
            out_pix_next.green = grey;
            out_pix_next.red   = grey;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cls_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pix_reg <= out_pix_next;
            was_red_reg <= fix;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blue  = out_pix_reg.blue;
    assign out_green = out_pix_reg.green;
    assign out_red   = out_pix_reg.red;
    assign was_red   = was_red_reg;

endmodule

@@ design/rep_cfg_regs.sv @@
// Configuration register file of the red-eye pixel correction core.
module rep_cfg_regs
    import rep_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_METHOD_SELECT: cfg_next.method_select = cfg_data[1:0];
                REG_RED_MIN:       cfg_next.red_min       = cfg_data;
                REG_OTHER_MAX:     cfg_next.other_max     = cfg_data;
                REG_HUE_LOW:       cfg_next.hue_low       = cfg_data;
                REG_HUE_HIGH:      cfg_next.hue_high      = cfg_data;
                REG_SAT_MIN:       cfg_next.sat_min       = cfg_data;
                REG_VAL_MIN:       cfg_next.val_min       = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method_select <= METHOD_RGB;
            cfg_reg.red_min       <= 8'd150;
            cfg_reg.other_max     <= 8'd100;
            cfg_reg.hue_low       <= 8'd10;
            cfg_reg.hue_high      <= 8'd160;
            cfg_reg.sat_min       <= 8'd100;
            cfg_reg.val_min       <= 8'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/rep_classify.sv @@
// Four-stage red classification pipeline: input, HSV terms, products, compares.
module rep_classify
    import rep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic in_load,
    input  pix_t in_pix,
    input  cfg_t cfg,
    output logic out_valid,
    output pix_t out_pix,
    output logic out_is_red
);

    // stage 1: raw pixel
    logic s1_valid_reg;
    pix_t s1_pix_reg;

    // stage 2: max, delta, hue numerator, simple methods
    logic              s2_valid_reg;
    pix_t              s2_pix_reg;
    logic [7:0]        s2_v_reg;
    logic [7:0]        s2_d_reg;
    logic signed [11:0] s2_num_reg;
    logic              s2_rgb_red_reg;
    logic              s2_ratio_red_reg;
    logic [7:0]        s2_v_next;
    logic [7:0]        s2_d_next;
    logic signed [11:0] s2_num_next;
    logic              s2_rgb_red_next;
    logic              s2_ratio_red_next;

    // stage 3: hue dividend and threshold products
    logic               s3_valid_reg;
    pix_t               s3_pix_reg;
    logic               s3_rgb_red_reg;
    logic               s3_ratio_red_reg;
    logic               s3_d_zero_reg;
    logic               s3_val_ok_reg;
    logic signed [18:0] s3_n_reg;
    logic [14:0]        s3_n120_reg;
    logic signed [19:0] s3_lo_a_reg;
    logic signed [19:0] s3_lo_b_reg;
    logic signed [19:0] s3_hi_a_reg;
    logic signed [19:0] s3_hi_b_reg;
    logic [16:0]        s3_s_num_reg;
    logic [16:0]        s3_s_den_reg;
    logic signed [18:0] s3_n_next;
    logic [14:0]        s3_n120_next;
    logic signed [19:0] s3_lo_a_next;
    logic signed [19:0] s3_lo_b_next;
    logic signed [19:0] s3_hi_a_next;
    logic signed [19:0] s3_hi_b_next;
    logic [16:0]        s3_s_num_next;
    logic [16:0]        s3_s_den_next;

    // stage 4: decision
    logic s4_valid_reg;
    pix_t s4_pix_reg;
    logic s4_red_reg;
    logic s4_red_next;

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [9:0]         sum;
    logic signed [11:0] rs;
    logic signed [11:0] gs;
    logic signed [11:0] bs;
    logic signed [11:0] ds;
    logic signed [9:0]  twod;
    logic signed [9:0]  k_lo_a;
    logic signed [9:0]  k_lo_b;
    logic signed [9:0]  k_hi_a;
    logic signed [9:0]  k_hi_b;
    logic [8:0]         sat_p1;
    logic signed [19:0] nx;
    logic signed [19:0] n120x;
    logic               ge60;
    logic               hue_lo_hit;
    logic               hue_hi_hit;
    logic               sat_ok;
    logic               hsv_red;

    always_comb
    begin
        mx = s1_pix_reg.red;
        if (s1_pix_reg.green > mx) mx = s1_pix_reg.green;
        if (s1_pix_reg.blue > mx)  mx = s1_pix_reg.blue;
        mn = s1_pix_reg.red;
        if (s1_pix_reg.green < mn) mn = s1_pix_reg.green;
        if (s1_pix_reg.blue < mn)  mn = s1_pix_reg.blue;
        s2_v_next = mx;
        s2_d_next = mx - mn;
        rs = $signed({4'b0, s1_pix_reg.red});
        gs = $signed({4'b0, s1_pix_reg.green});
        bs = $signed({4'b0, s1_pix_reg.blue});
        ds = $signed({4'b0, s2_d_next});
        if (mx == s1_pix_reg.red)
            s2_num_next = gs - bs;
        else if (mx == s1_pix_reg.green)
            s2_num_next = bs - rs + (ds <<< 1);
        else
            s2_num_next = rs - gs + (ds <<< 2);
        sum = {2'b0, s1_pix_reg.red} + {2'b0, s1_pix_reg.green} + {2'b0, s1_pix_reg.blue};
        s2_rgb_red_next = (s1_pix_reg.red > cfg.red_min)
                       && (s1_pix_reg.green < cfg.other_max)
                       && (s1_pix_reg.blue < cfg.other_max);
        s2_ratio_red_next = (sum != 10'd0)
                         && (({4'b0, s1_pix_reg.red} * 12'd5) > ({2'b0, sum} * 12'd3));
    end

    always_comb
    begin
        twod   = $signed({1'b0, s2_d_reg, 1'b0});
        k_lo_a = $signed({2'b0, cfg.hue_low}) + 10'sd60;
        k_lo_b = $signed({2'b0, cfg.hue_low}) - 10'sd120;
        k_hi_a = $signed({2'b0, cfg.hue_high}) + 10'sd61;
        k_hi_b = $signed({2'b0, cfg.hue_high}) - 10'sd119;
        s3_lo_a_next = 20'(k_lo_a) * 20'(twod);
        s3_lo_b_next = 20'(k_lo_b) * 20'(twod);
        s3_hi_a_next = 20'(k_hi_a) * 20'(twod);
        s3_hi_b_next = 20'(k_hi_b) * 20'(twod);
        s3_n_next = 19'(s2_num_reg) * 19'sd60 + $signed({11'b0, s2_d_reg}) * 19'sd121;
        s3_n120_next = 15'({7'b0, s2_d_reg} * 15'd120);
        sat_p1 = {1'b0, cfg.sat_min} + 9'd1;
        s3_s_num_next = 17'({9'b0, s2_d_reg} * 17'd510) + {9'b0, s2_v_reg};
        s3_s_den_next = 17'({8'b0, sat_p1} * {8'b0, s2_v_reg, 1'b0});
    end

    always_comb
    begin
        nx    = 20'(s3_n_reg);
        n120x = $signed({5'b0, s3_n120_reg});
        ge60  = nx >= n120x;
        if (s3_d_zero_reg)
        begin
            hue_lo_hit = cfg.hue_low != 8'd0;
            hue_hi_hit = 1'b0;
        end
        else if (ge60)
        begin
            hue_lo_hit = !(nx >= s3_lo_a_reg);
            hue_hi_hit = nx >= s3_hi_a_reg;
        end
        else
        begin
            hue_lo_hit = !(nx >= s3_lo_b_reg);
            hue_hi_hit = nx >= s3_hi_b_reg;
        end
        sat_ok  = s3_s_num_reg >= s3_s_den_reg;
        hsv_red = (hue_lo_hit || hue_hi_hit) && sat_ok && s3_val_ok_reg;
        case (cfg.method_select)
            METHOD_RGB:   s4_red_next = s3_rgb_red_reg;
            METHOD_RATIO: s4_red_next = s3_ratio_red_reg;
            METHOD_HSV:   s4_red_next = hsv_red;
            default:      s4_red_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_load;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pix_reg        <= in_pix;
            s2_pix_reg        <= s1_pix_reg;
            s2_v_reg          <= s2_v_next;
            s2_d_reg          <= s2_d_next;
            s2_num_reg        <= s2_num_next;
            s2_rgb_red_reg    <= s2_rgb_red_next;
            s2_ratio_red_reg  <= s2_ratio_red_next;
            s3_pix_reg        <= s2_pix_reg;
            s3_rgb_red_reg    <= s2_rgb_red_reg;
            s3_ratio_red_reg  <= s2_ratio_red_reg;
            s3_d_zero_reg     <= s2_d_reg == 8'd0;
            s3_val_ok_reg     <= (s2_v_reg > cfg.val_min) && (s2_v_reg != 8'd0);
            s3_n_reg          <= s3_n_next;
            s3_n120_reg       <= s3_n120_next;
            s3_lo_a_reg       <= s3_lo_a_next;
            s3_lo_b_reg       <= s3_lo_b_next;
            s3_hi_a_reg       <= s3_hi_a_next;
            s3_hi_b_reg       <= s3_hi_b_next;
            s3_s_num_reg      <= s3_s_num_next;
            s3_s_den_reg      <= s3_s_den_next;
            s4_pix_reg        <= s3_pix_reg;
            s4_red_reg        <= s4_red_next;
        end
    end

    assign out_valid  = s4_valid_reg;
    assign out_pix    = s4_pix_reg;
    assign out_is_red = s4_red_reg;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for red_eye_pixel_correct_core: random and corner pixels, all methods.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rep_pkg::*;

    localparam logic [1:0] METHOD_NONE = 2'd3;
    localparam int LIMIT_NS = 400000;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       was_red;
    } result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             in_blue = '0;
    logic [7:0]             in_green = '0;
    logic [7:0]             in_red = '0;
    logic                   in_eye = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             out_blue;
    logic [7:0]             out_green;
    logic [7:0]             out_red;
    logic                   was_red;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cfg_t    cfg_now;
    pix_t    pixel_q[$];
    result_t expected_pixels[$];
    result_t want;
    pix_t    next_pix;
    bit      in_taken = 1'b0;
    bit      no_gaps = 1'b0;
    int      errors = 0;
    int      words_checked = 0;
    int      grey_count = 0;
    int      settings_seen = 0;

    pix_t corner_pixels [8] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1},
        '{8'd255, 8'd255, 8'd255, 1'b1},
        '{8'd0,   8'd0,   8'd255, 1'b1},
        '{8'd0,   8'd0,   8'd255, 1'b0},
        '{8'd99,  8'd99,  8'd151, 1'b1},
        '{8'd80,  8'd50,  8'd200, 1'b1},
        '{8'd1,   8'd1,   8'd3,   1'b1},
        '{8'd0,   8'd1,   8'd3,   1'b1}
    };

    red_eye_pixel_correct_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_blue   (in_blue),
        .in_green  (in_green),
        .in_red    (in_red),
        .in_eye    (in_eye),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .was_red   (was_red),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic result_t correct_pixel(pix_t p, cfg_t c);
        int         r;
        int         g;
        int         b;
        int         v;
        int         mn;
        int         d;
        int         s;
        int         num;
        int         h;
        bit         red;
        logic [8:0] grey_sum;
        result_t    res;
        r = int'(p.red);
        g = int'(p.green);
        b = int'(p.blue);
        v = r;
        mn = r;
        if (g > v) v = g;
        if (b > v) v = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = v - mn;
        s = (v == 0) ? 0 : (510 * d + v) / (2 * v);
        h = 0;
        if (d != 0)
        begin
            if (v == r)
                num = g - b;
            else if (v == g)
                num = b - r + 2 * d;
            else
                num = r - g + 4 * d;
            h = (60 * num + 121 * d) / (2 * d) - 60;
            if (h < 0)
                h += 180;
        end
        case (c.method_select)
            METHOD_RGB:
                red = r > int'(c.red_min) && g < int'(c.other_max) && b < int'(c.other_max);
            METHOD_RATIO:
                red = (r + g + b) != 0 && 5 * r > 3 * (r + g + b);
            METHOD_HSV:
                red = (h < int'(c.hue_low) || h > int'(c.hue_high)) &&
                      s > int'(c.sat_min) && v > int'(c.val_min);
            default:
                red = 1'b0;
        endcase
        grey_sum = {1'b0, p.green} + {1'b0, p.blue};
        if (red && p.eye)
            res = '{grey_sum[8:1], grey_sum[8:1], grey_sum[8:1], 1'b1};
        else
            res = '{p.blue, p.green, p.red, 1'b0};
        return res;
    endfunction

    function automatic pix_t random_pixel();
        pix_t p;
        int   kind;
        kind = int'($urandom_range(9));
        p.blue = 8'($urandom_range(255));
        p.green = 8'($urandom_range(255));
        p.red = 8'($urandom_range(255));
        p.eye = ($urandom_range(3) != 0);
        if (kind >= 4 && kind < 8)
        begin
            // red-dominant pixels reach the red branches of every method
            p.red = 8'($urandom_range(255, 120));
            p.green = 8'($urandom_range(140));
            p.blue = 8'($urandom_range(140));
        end
        else if (kind == 8)
        begin
            p.green = p.red;
            p.blue = p.red;
        end
        else if (kind == 9)
        begin
            p.red = 8'(int'(cfg_now.red_min) + int'($urandom_range(2)) - 1);
            p.green = 8'(int'(cfg_now.other_max) - int'($urandom_range(1)));
        end
        return p;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
        if (got !== exp_val)
            flag_error($sformatf("%s is %h, expected %h", name, got, exp_val));
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_METHOD_SELECT: cfg_now.method_select = data[1:0];
            REG_RED_MIN:       cfg_now.red_min = data;
            REG_OTHER_MAX:     cfg_now.other_max = data;
            REG_HUE_LOW:       cfg_now.hue_low = data;
            REG_HUE_HIGH:      cfg_now.hue_high = data;
            REG_SAT_MIN:       cfg_now.sat_min = data;
            REG_VAL_MIN:       cfg_now.val_min = data;
            default:           ;
        endcase
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while ((pixel_q.size() != 0 || in_valid || expected_pixels.size() != 0) &&
               n < DRAIN_LIMIT);
    endtask

    task automatic run_phase(logic [7:0] method, logic [7:0] rmin, logic [7:0] omax,
                             logic [7:0] hlo, logic [7:0] hhi, logic [7:0] smin,
                             logic [7:0] vmin, bit with_corners, int count);
        write_reg(REG_METHOD_SELECT, method);
        write_reg(REG_RED_MIN, rmin);
        write_reg(REG_OTHER_MAX, omax);
        write_reg(REG_HUE_LOW, hlo);
        write_reg(REG_HUE_HIGH, hhi);
        write_reg(REG_SAT_MIN, smin);
        write_reg(REG_VAL_MIN, vmin);
        settings_seen++;
        @(posedge clk);
        if (with_corners)
            foreach (corner_pixels[i])
                pixel_q.push_back(corner_pixels[i]);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(random_pixel());
        wait_drained();
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d words outstanding", expected_pixels.size());
        $display("tb_top failed");
        $finish;
    end

    // sample handshakes and check results
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                flag_error($sformatf("word %h/%h/%h/%b with nothing pending",
                                     out_blue, out_green, out_red, was_red));
            else
            begin
                want = expected_pixels.pop_front();
                words_checked++;
                if (want.was_red)
                    grey_count++;
                check_field("out_blue", out_blue, want.blue);
                check_field("out_green", out_green, want.green);
                check_field("out_red", out_red, want.red);
                check_field("was_red", {7'b0, was_red}, {7'b0, want.was_red});
            end
        end
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            expected_pixels.push_back(correct_pixel({in_blue, in_green, in_red, in_eye}, cfg_now));
    end

    // drive words and output stall
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pixel_q.size() != 0 && (no_gaps || $urandom_range(99) >= 18))
            begin
                next_pix = pixel_q.pop_front();
                in_valid <= 1'b1;
                in_blue <= next_pix.blue;
                in_green <= next_pix.green;
                in_red <= next_pix.red;
                in_eye <= next_pix.eye;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= rst_n && !no_gaps && ($urandom_range(99) < 18);
    end

    initial
    begin
        cfg_now = '{method_select: METHOD_RGB, red_min: 8'd150, other_max: 8'd100,
                    hue_low: 8'd10, hue_high: 8'd160, sat_min: 8'd100, val_min: 8'd100};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset defaults checked before any write
        foreach (corner_pixels[i])
            pixel_q.push_back(corner_pixels[i]);
        wait_drained();
        run_phase({6'b0, METHOD_RGB}, 8'd150, 8'd100, 8'd10, 8'd160, 8'd100, 8'd100,
                  1'b0, 150);
        run_phase({6'b0, METHOD_RATIO}, 8'd0, 8'd255, 8'd10, 8'd160, 8'd100, 8'd100,
                  1'b1, 220);
        no_gaps = 1'b1;
        run_phase({6'b0, METHOD_HSV}, 8'd150, 8'd100, 8'd10, 8'd160, 8'd100, 8'd100,
                  1'b1, 200);
        no_gaps = 1'b0;
        run_phase({6'b0, METHOD_HSV}, 8'd150, 8'd100, 8'd0, 8'd180, 8'd0, 8'd0, 1'b0, 150);
        run_phase({6'b0, METHOD_HSV}, 8'd150, 8'd100, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 150);
        run_phase({6'b0, METHOD_HSV}, 8'd150, 8'd100, 8'd20, 8'd150, 8'd50, 8'd50, 1'b0, 200);
        run_phase({6'b0, METHOD_HSV}, 8'd150, 8'd100, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 60);
        run_phase({6'b0, METHOD_RGB}, 8'd0, 8'd255, 8'd10, 8'd160, 8'd100, 8'd100, 1'b0, 150);
        run_phase({6'b0, METHOD_RGB}, 8'd255, 8'd0, 8'd10, 8'd160, 8'd100, 8'd100, 1'b0, 100);
        run_phase({6'h3F, METHOD_NONE}, 8'd150, 8'd100, 8'd10, 8'd160, 8'd100, 8'd100,
                  1'b0, 100);
        run_phase({6'h3F, METHOD_RATIO}, 8'd150, 8'd100, 8'd10, 8'd160, 8'd100, 8'd100,
                  1'b0, 150);
        run_phase({6'b0, METHOD_RGB}, 8'd120, 8'd140, 8'd10, 8'd160, 8'd100, 8'd100,
                  1'b0, 150);
        repeat (10) @(posedge clk);
        if (expected_pixels.size() != 0)
            flag_error($sformatf("%0d words never came out", expected_pixels.size()));
        $display("checked %0d words under %0d register settings, %0d replaced by grey",
                 words_checked, settings_seen, grey_count);
        $display("methods covered: RGB threshold, red ratio, HSV window and unused selector");
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
